[rtl/kti_pkg.sv]
package kti_pkg;

  localparam int REG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int DIV_NUM_W  = 50;
  localparam int DIV_DEN_W  = 32;
  localparam int DIV_CNT_W  = $clog2(DIV_NUM_W);

  localparam logic [1:0] ACT_CLEAR     = 2'd0;
  localparam logic [1:0] ACT_ADD_TRANS = 2'd1;
  localparam logic [1:0] ACT_ADD_ROT   = 2'd2;
  localparam logic [1:0] ACT_QUERY     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_CYC_FIRST    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CYC_LAST     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD = 2'd2;

  localparam logic [REG_W-1:0] DEFAULT_PERIOD = 16'd2187;
  localparam logic [REG_W-1:0] RESET_LAST     = 16'hFFFF;
  localparam logic signed [15:0] QUAT_ONE     = 16'sd16384;

  typedef struct packed {
    logic [1:0]         action;
    logic [15:0]        frame;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } in_word_t;

  typedef struct packed {
    logic               has_position;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic               has_rotation;
    logic signed [15:0] out_quat_x;
    logic signed [15:0] out_quat_y;
    logic signed [15:0] out_quat_z;
    logic signed [15:0] out_quat_w;
    logic [31:0]        local_time;
    logic               in_range;
  } out_word_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_COPY,
    MODE_INTERP
  } trk_mode_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_T_BEGIN,
    ST_T_RD,
    ST_T_CHK,
    ST_T_MUL,
    ST_T_GO,
    ST_T_WAIT,
    ST_R_BEGIN,
    ST_R_RD,
    ST_R_CHK,
    ST_R_DOT,
    ST_R_MUL,
    ST_R_GO,
    ST_R_WAIT,
    ST_R_SQ,
    ST_R_SQTEST,
    ST_R_SQRT,
    ST_R_NGO,
    ST_R_NWAIT,
    ST_FIN
  } state_t;

endpackage

[rtl/kti_ram.sv]
module kti_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/kti_div.sv]
module kti_div (
  input  logic              clk,
  input  logic              rst,
  input  kti_pkg::div_req_t req,
  output kti_pkg::div_rsp_t rsp
);
  import kti_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_NUM_W-1:0] quo;
  logic [DIV_DEN_W:0]   trial;

  assign trial = {rem, quo[DIV_NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0);
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
      end
    end
    if (req.start) begin
      quo <= req.num;
      den <= req.den;
      rem <= '0;
      cnt <= DIV_CNT_W'(DIV_NUM_W - 1);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (trial >= {1'b0, den}) begin
        rem <= DIV_DEN_W'(trial - {1'b0, den});
        quo <= {quo[DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem <= trial[DIV_DEN_W-1:0];
        quo <= {quo[DIV_NUM_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quo;

endmodule

[rtl/keyframe_track_interpolator.sv]
// Holds one bone track of up to MAX_KEYS translation keys and MAX_KEYS rotation keys,
// loaded in ascending frame order; a query word returns the lerped position, the
// nlerped and renormalized rotation, the local time and the cycle range flag. Key
// words and clears give no result. A query walks the stored keys of each track,
// then runs one divide per interpolated component on the shared serial divider
// (3 for position, 4 for rotation), a bit-serial square root and 4 more divides
// for normalization; end clamps copy a key and run no divides. The shared
// bit-serial divider and the single read port of each key memory set the query
// time. The result waits in an output register, so key words are taken while it
// is stalled.
module keyframe_track_interpolator #(
  parameter int MAX_KEYS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  kti_pkg::in_word_t                   in_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output kti_pkg::out_word_t                  out_word,
  input  logic                                cfg_write,
  input  logic [kti_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [kti_pkg::REG_W-1:0]           cfg_data
);
  import kti_pkg::*;

  localparam int CNT_W  = $clog2(MAX_KEYS + 1);
  localparam int ADDR_W = $clog2(MAX_KEYS);

  state_t state, state_next;

  logic [15:0] cyc_first, cyc_last, frame_period;

  logic [CNT_W-1:0] t_count, r_count;
  logic [15:0]      t_first, t_last, r_first, r_last;

  logic              t_we, r_we;
  logic [ADDR_W-1:0] raddr;
  logic [111:0]      t_wdata, t_rdata;
  logic [79:0]       r_wdata, r_rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  trk_mode_t         t_mode, r_mode;
  logic [ADDR_W-1:0] r_start, ptr;
  logic [15:0]       qf, num, seg;
  logic [111:0]      t_prev, t_cur;
  logic [79:0]       r_prev, r_cur;
  logic [1:0]        comp;
  logic signed [49:0] prod;
  logic              div_neg;
  logic signed [34:0] dot;
  logic signed [17:0] rq [4];
  logic [32:0]       ssum;
  logic [62:0]       sx, sres;
  logic [4:0]        sidx;
  logic [31:0]       rnorm;
  logic signed [31:0] pos [3];
  logic signed [15:0] oq [4];
  logic [31:0]       ltime;
  logic              range_ok;

  logic              accept, fin_free;
  logic              t_adv, r_adv;
  logic              t_add_ok, r_add_ok;
  logic [15:0]       period;
  logic signed [31:0] t_a, t_b;
  logic signed [15:0] r_a, r_b;
  logic signed [17:0] r_bn, r_a18;
  logic signed [49:0] prod_mag_s;
  logic [49:0]       prod_mag;
  logic [62:0]       sbit, strial;
  logic [17:0]       rq_mag;
  logic [15:0]       sat_q;
  logic [31:0]       last_addr_t, last_addr_r;

  assign accept   = in_valid && !in_stall;
  assign fin_free = !out_valid || !out_stall;
  assign t_adv    = (ptr == '0) || (t_rdata[111:96] < qf);
  assign r_adv    = (ptr == '0) || (r_rdata[79:64] < qf);
  assign t_add_ok = (t_count != CNT_W'(MAX_KEYS)) &&
                    ((t_count == '0) || (in_word.frame >= t_last));
  assign r_add_ok = (r_count != CNT_W'(MAX_KEYS)) &&
                    ((r_count == '0) || (in_word.frame >= r_last));
  assign period   = (frame_period == '0) ? DEFAULT_PERIOD : frame_period;

  assign t_a   = t_prev[{comp, 5'b0} +: 32];
  assign t_b   = t_cur[{comp, 5'b0} +: 32];
  assign r_a   = r_prev[{comp, 4'b0} +: 16];
  assign r_b   = r_cur[{comp, 4'b0} +: 16];
  assign r_a18 = 18'(r_a);
  assign r_bn  = dot[34] ? -18'(r_b) : 18'(r_b);

  assign prod_mag_s = prod[49] ? -prod : prod;
  assign prod_mag   = prod_mag_s;
  assign rq_mag     = rq[comp][17] ? 18'(-rq[comp]) : 18'(rq[comp]);
  assign sbit       = 63'(1) << {sidx, 1'b0};
  assign strial     = sres + sbit;

  assign last_addr_t = 32'(t_count) - 32'd1;
  assign last_addr_r = 32'(r_count) - 32'd1;

  assign t_wdata = {in_word.frame, in_word.pos_z, in_word.pos_y, in_word.pos_x};
  assign r_wdata = {in_word.frame, in_word.quat_w, in_word.quat_z, in_word.quat_y,
                    in_word.quat_x};

  always_comb begin
    if (!div_neg) begin
      sat_q = (div_rsp.quot > 50'd32767) ? 16'h7FFF : div_rsp.quot[15:0];
    end else begin
      sat_q = (div_rsp.quot > 50'd32768) ? 16'h8000 : 16'(-div_rsp.quot[15:0]);
    end
  end

  kti_ram #(.WIDTH(112), .DEPTH(MAX_KEYS)) u_trans_ram (
    .clk(clk), .we(t_we), .waddr(t_count[ADDR_W-1:0]), .wdata(t_wdata),
    .raddr(raddr), .rdata(t_rdata)
  );

  kti_ram #(.WIDTH(80), .DEPTH(MAX_KEYS)) u_rot_ram (
    .clk(clk), .we(r_we), .waddr(r_count[ADDR_W-1:0]), .wdata(r_wdata),
    .raddr(raddr), .rdata(r_rdata)
  );

  kti_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (accept && in_word.action == ACT_QUERY) state_next = ST_T_BEGIN;
      ST_T_BEGIN:  state_next = (t_mode == MODE_NONE) ? ST_R_BEGIN : ST_T_RD;
      ST_T_RD:     state_next = ST_T_CHK;
      ST_T_CHK: begin
        if (t_mode == MODE_COPY) state_next = ST_R_BEGIN;
        else if (t_adv) state_next = ST_T_RD;
        else state_next = ST_T_MUL;
      end
      ST_T_MUL:    state_next = ST_T_GO;
      ST_T_GO:     state_next = ST_T_WAIT;
      ST_T_WAIT:   if (div_rsp.done) state_next = (comp == 2'd2) ? ST_R_BEGIN : ST_T_MUL;
      ST_R_BEGIN:  state_next = (r_mode == MODE_NONE) ? ST_FIN : ST_R_RD;
      ST_R_RD:     state_next = ST_R_CHK;
      ST_R_CHK: begin
        if (r_mode == MODE_COPY) state_next = ST_FIN;
        else if (r_adv) state_next = ST_R_RD;
        else state_next = ST_R_DOT;
      end
      ST_R_DOT:    if (comp == 2'd3) state_next = ST_R_MUL;
      ST_R_MUL:    state_next = ST_R_GO;
      ST_R_GO:     state_next = ST_R_WAIT;
      ST_R_WAIT:   if (div_rsp.done) state_next = (comp == 2'd3) ? ST_R_SQ : ST_R_MUL;
      ST_R_SQ:     if (comp == 2'd3) state_next = ST_R_SQTEST;
      ST_R_SQTEST: state_next = (ssum == '0) ? ST_FIN : ST_R_SQRT;
      ST_R_SQRT:   if (sidx == '0) state_next = ST_R_NGO;
      ST_R_NGO:    state_next = ST_R_NWAIT;
      ST_R_NWAIT:  if (div_rsp.done) state_next = (comp == 2'd3) ? ST_FIN : ST_R_NGO;
      ST_FIN:      if (fin_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = (state != ST_IDLE);
    t_we          = 1'b0;
    r_we          = 1'b0;
    raddr         = ptr;
    div_req.start = 1'b0;
    div_req.num   = prod_mag + 50'(seg >> 1);
    div_req.den   = 32'(seg);
    unique case (state)
      ST_IDLE: begin
        t_we = accept && in_word.action == ACT_ADD_TRANS && t_add_ok;
        r_we = accept && in_word.action == ACT_ADD_ROT && r_add_ok;
      end
      ST_T_GO, ST_R_GO: div_req.start = 1'b1;
      ST_R_NGO: begin
        div_req.start = 1'b1;
        div_req.num   = (50'(rq_mag) << 28) + 50'(rnorm >> 1);
        div_req.den   = rnorm;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cyc_first    <= '0;
      cyc_last     <= RESET_LAST;
      frame_period <= DEFAULT_PERIOD;
      t_count      <= '0;
      r_count      <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_CYC_FIRST:    cyc_first    <= cfg_data;
          REG_CYC_LAST:     cyc_last     <= cfg_data;
          REG_FRAME_PERIOD: frame_period <= cfg_data;
          default: ;
        endcase
      end
      if (accept && in_word.action == ACT_CLEAR) begin
        t_count <= '0;
        r_count <= '0;
      end
      if (t_we) t_count <= t_count + 1'b1;
      if (r_we) r_count <= r_count + 1'b1;
      if (state == ST_FIN && fin_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      if (t_count == '0) t_first <= in_word.frame;
      t_last <= in_word.frame;
    end
    if (r_we) begin
      if (r_count == '0) r_first <= in_word.frame;
      r_last <= in_word.frame;
    end

    case (state)
      ST_IDLE: begin
        if (accept && in_word.action == ACT_QUERY) begin
          qf       <= in_word.frame;
          ltime    <= (in_word.frame >= cyc_first) ?
                      32'(in_word.frame - cyc_first) * 32'(period) : '0;
          range_ok <= (in_word.frame >= cyc_first) && (in_word.frame <= cyc_last);
          comp     <= '0;
          if (t_count == '0) begin
            t_mode <= MODE_NONE;
          end else if (t_count == CNT_W'(1) || in_word.frame <= t_first) begin
            t_mode <= MODE_COPY;
            ptr    <= '0;
          end else if (in_word.frame >= t_last) begin
            t_mode <= MODE_COPY;
            ptr    <= last_addr_t[ADDR_W-1:0];
          end else begin
            t_mode <= MODE_INTERP;
            ptr    <= '0;
          end
          r_start <= '0;
          if (r_count == '0) begin
            r_mode <= MODE_NONE;
          end else if (r_count == CNT_W'(1) || in_word.frame <= r_first) begin
            r_mode <= MODE_COPY;
          end else if (in_word.frame >= r_last) begin
            r_mode  <= MODE_COPY;
            r_start <= last_addr_r[ADDR_W-1:0];
          end else begin
            r_mode <= MODE_INTERP;
          end
        end
      end
      ST_T_BEGIN: begin
        if (t_mode == MODE_NONE) begin
          pos[0] <= '0;
          pos[1] <= '0;
          pos[2] <= '0;
        end
      end
      ST_T_CHK: begin
        if (t_mode == MODE_COPY) begin
          pos[0] <= t_rdata[31:0];
          pos[1] <= t_rdata[63:32];
          pos[2] <= t_rdata[95:64];
        end else if (t_adv) begin
          t_prev <= t_rdata;
          ptr    <= ptr + 1'b1;
        end else begin
          t_cur <= t_rdata;
          num   <= qf - t_prev[111:96];
          seg   <= t_rdata[111:96] - t_prev[111:96];
          comp  <= '0;
        end
      end
      ST_T_MUL: prod <= 50'((33'(t_b) - 33'(t_a)) * $signed({17'b0, num}));
      ST_T_GO:  div_neg <= prod[49];
      ST_T_WAIT: begin
        if (div_rsp.done) begin
          pos[comp] <= t_a + (div_neg ? -32'(div_rsp.quot) : 32'(div_rsp.quot));
          comp      <= (comp == 2'd2) ? 2'd0 : comp + 1'b1;
        end
      end
      ST_R_BEGIN: begin
        ptr  <= r_start;
        comp <= '0;
        if (r_mode == MODE_NONE) begin
          oq[0] <= '0;
          oq[1] <= '0;
          oq[2] <= '0;
          oq[3] <= QUAT_ONE;
        end
      end
      ST_R_CHK: begin
        if (r_mode == MODE_COPY) begin
          oq[0] <= r_rdata[15:0];
          oq[1] <= r_rdata[31:16];
          oq[2] <= r_rdata[47:32];
          oq[3] <= r_rdata[63:48];
        end else if (r_adv) begin
          r_prev <= r_rdata;
          ptr    <= ptr + 1'b1;
        end else begin
          r_cur <= r_rdata;
          num   <= qf - r_prev[79:64];
          seg   <= r_rdata[79:64] - r_prev[79:64];
          dot   <= '0;
          ssum  <= '0;
          comp  <= '0;
        end
      end
      ST_R_DOT: begin
        dot  <= dot + 35'(r_a * r_b);
        comp <= comp + 1'b1;
      end
      ST_R_MUL: prod <= 50'((19'(r_bn) - 19'(r_a18)) * $signed({17'b0, num}));
      ST_R_GO:  div_neg <= prod[49];
      ST_R_WAIT: begin
        if (div_rsp.done) begin
          rq[comp] <= r_a18 + (div_neg ? -18'(div_rsp.quot) : 18'(div_rsp.quot));
          comp     <= comp + 1'b1;
        end
      end
      ST_R_SQ: begin
        ssum <= ssum + 33'(rq[comp] * rq[comp]);
        comp <= comp + 1'b1;
      end
      ST_R_SQTEST: begin
        sx   <= 63'({ssum, 28'b0});
        sres <= '0;
        sidx <= 5'd31;
        if (ssum == '0) begin
          oq[0] <= 16'(rq[0]);
          oq[1] <= 16'(rq[1]);
          oq[2] <= 16'(rq[2]);
          oq[3] <= 16'(rq[3]);
        end
      end
      ST_R_SQRT: begin
        if (sx >= strial) begin
          sx   <= sx - strial;
          sres <= (sres >> 1) + sbit;
        end else begin
          sres <= sres >> 1;
        end
        sidx <= sidx - 1'b1;
        if (sidx == '0) begin
          rnorm <= (sx >= strial) ? 32'((sres >> 1) + sbit) : 32'(sres >> 1);
          comp  <= '0;
        end
      end
      ST_R_NGO: div_neg <= rq[comp][17];
      ST_R_NWAIT: begin
        if (div_rsp.done) begin
          oq[comp] <= sat_q;
          comp     <= comp + 1'b1;
        end
      end
      ST_FIN: begin
        if (fin_free) begin
          out_word.has_position <= (t_mode != MODE_NONE);
          out_word.out_pos_x    <= pos[0];
          out_word.out_pos_y    <= pos[1];
          out_word.out_pos_z    <= pos[2];
          out_word.has_rotation <= (r_mode != MODE_NONE);
          out_word.out_quat_x   <= oq[0];
          out_word.out_quat_y   <= oq[1];
          out_word.out_quat_z   <= oq[2];
          out_word.out_quat_w   <= oq[3];
          out_word.local_time   <= ltime;
          out_word.in_range     <= range_ok;
        end
      end
      default: ;
    endcase
  end

endmodule

[rtl/kti_checker.sv]
module kti_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input kti_pkg::in_word_t             in_word,
  input logic                          out_valid,
  input logic                          out_stall,
  input kti_pkg::out_word_t            out_word
);
  import kti_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_word.action == ACT_QUERY |=> in_stall)
    else $error("query accepted without going busy");

  a_no_rot: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.has_rotation |->
      out_word.out_quat_x == 16'sd0 && out_word.out_quat_y == 16'sd0 &&
      out_word.out_quat_z == 16'sd0 && out_word.out_quat_w == QUAT_ONE)
    else $error("empty rotation track is not identity");

  a_no_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.has_position |->
      out_word.out_pos_x == 32'sd0 && out_word.out_pos_y == 32'sd0 &&
      out_word.out_pos_z == 32'sd0)
    else $error("empty translation track is not zero");

endmodule

bind keyframe_track_interpolator kti_checker u_kti_checker (.*);
